// File: sv/assert_macros.svh
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define BMD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BMD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: sv/bmd_pkg.sv
// types, codes and address constants of the banked memory bus decoder
package bmd_pkg;

    localparam int WRAM_BYTES_DEF = 32768;
    localparam int HRAM_BYTES     = 127;
    localparam int HRAM_AW        = 7;
    localparam int QUEUE_DEPTH    = 4;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;

    localparam logic [15:0] ADDR_CART_LO_END = 16'h7FFF;
    localparam logic [15:0] ADDR_VRAM_END    = 16'h9FFF;
    localparam logic [15:0] ADDR_CART_HI_END = 16'hBFFF;
    localparam logic [15:0] ADDR_WRAM_END    = 16'hFDFF;
    localparam logic [15:0] ADDR_OAM_END     = 16'hFE9F;
    localparam logic [15:0] ADDR_HOLE_END    = 16'hFEFF;
    localparam logic [15:0] ADDR_JOYPAD      = 16'hFF00;
    localparam logic [15:0] ADDR_SB          = 16'hFF01;
    localparam logic [15:0] ADDR_SC          = 16'hFF02;
    localparam logic [15:0] ADDR_TIMER_LO    = 16'hFF04;
    localparam logic [15:0] ADDR_TIMER_HI    = 16'hFF07;
    localparam logic [15:0] ADDR_IF          = 16'hFF0F;
    localparam logic [15:0] ADDR_OAM_DMA     = 16'hFF46;
    localparam logic [15:0] ADDR_KEY1        = 16'hFF4D;
    localparam logic [15:0] ADDR_SVBK        = 16'hFF70;
    localparam logic [15:0] ADDR_HDMA_LO     = 16'hFF51;
    localparam logic [15:0] ADDR_HDMA_HI     = 16'hFF55;
    localparam logic [15:0] ADDR_HRAM_LO     = 16'hFF80;
    localparam logic [15:0] ADDR_IE          = 16'hFFFF;

    localparam logic [2:0] BANK_RESET = 3'd1;
    localparam int         BANK_SIZE_LOG2 = 12;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_SPEED = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        TGT_LOCAL    = 3'd0,
        TGT_CART     = 3'd1,
        TGT_VIDEO    = 3'd2,
        TGT_JOYPAD   = 3'd3,
        TGT_SERIAL   = 3'd4,
        TGT_TIMER    = 3'd5,
        TGT_HDMA     = 3'd6,
        TGT_UNMAPPED = 3'd7
    } t_target;

    typedef enum logic [2:0] {
        LOC_NONE,
        LOC_WRAM,
        LOC_IF,
        LOC_DMA,
        LOC_KEY1,
        LOC_SVBK,
        LOC_HRAM,
        LOC_IE
    } t_loc;

    typedef enum logic [1:0] {
        RSEL_REG,
        RSEL_WRAM,
        RSEL_HRAM
    } t_rsel;

    // one classified bus access as it waits in the queue
    typedef struct packed {
        t_func               func;
        t_target             target;
        t_loc                loc;
        logic                bank_sel;
        logic [11:0]         wram_low;
        logic [HRAM_AW-1:0]  hram_idx;
        logic [7:0]          wdata;
    } t_op;

endpackage

// File: sv/bmd_ram.sv
// generic single-port ram with registered read
module bmd_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bmd_front.sv
// front end: classifies an incoming bus word by function and address
module bmd_front (
    input  logic [bmd_pkg::IN_USER_W-1:0] i_func,
    input  logic [15:0]                   i_addr,
    input  logic [7:0]                    i_wdata,
    output bmd_pkg::t_op                  o_op
);
    import bmd_pkg::*;

    t_target w_target;
    t_loc    w_loc;
    t_func   w_func;

    assign w_func = t_func'(i_func);

    // address map decode
    always_comb begin
        w_target = TGT_UNMAPPED;
        w_loc    = LOC_NONE;
        if (i_addr <= ADDR_CART_LO_END) begin
            w_target = TGT_CART;
        end else if (i_addr <= ADDR_VRAM_END) begin
            w_target = TGT_VIDEO;
        end else if (i_addr <= ADDR_CART_HI_END) begin
            w_target = TGT_CART;
        end else if (i_addr <= ADDR_WRAM_END) begin
            w_target = TGT_LOCAL;
            w_loc    = LOC_WRAM;
        end else if (i_addr <= ADDR_OAM_END) begin
            w_target = TGT_VIDEO;
        end else if (i_addr <= ADDR_HOLE_END) begin
            w_target = TGT_UNMAPPED;
        end else if (i_addr == ADDR_JOYPAD) begin
            w_target = TGT_JOYPAD;
        end else if (i_addr inside {ADDR_SB, ADDR_SC}) begin
            w_target = TGT_SERIAL;
        end else if (i_addr inside {[ADDR_TIMER_LO:ADDR_TIMER_HI]}) begin
            w_target = TGT_TIMER;
        end else if (i_addr == ADDR_IF) begin
            w_target = TGT_LOCAL;
            w_loc    = LOC_IF;
        end else if (i_addr == ADDR_OAM_DMA) begin
            w_target = TGT_LOCAL;
            w_loc    = LOC_DMA;
        end else if (i_addr == ADDR_KEY1) begin
            w_target = TGT_LOCAL;
            w_loc    = LOC_KEY1;
        end else if (i_addr == ADDR_SVBK) begin
            w_target = TGT_LOCAL;
            w_loc    = LOC_SVBK;
        end else if (i_addr inside {[16'hFF40:16'hFF45], [16'hFF47:16'hFF4B], 16'hFF4F,
                                    [16'hFF68:16'hFF6B]}) begin
            w_target = TGT_VIDEO;
        end else if (i_addr inside {[ADDR_HDMA_LO:ADDR_HDMA_HI]}) begin
            w_target = TGT_HDMA;
        end else if (i_addr == ADDR_IE) begin
            w_target = TGT_LOCAL;
            w_loc    = LOC_IE;
        end else if (i_addr >= ADDR_HRAM_LO) begin
            w_target = TGT_LOCAL;
            w_loc    = LOC_HRAM;
        end
    end

    always_comb begin
        o_op.func     = w_func;
        o_op.bank_sel = i_addr[BANK_SIZE_LOG2];
        o_op.wram_low = i_addr[BANK_SIZE_LOG2-1:0];
        o_op.hram_idx = i_addr[HRAM_AW-1:0];
        o_op.wdata    = i_wdata;
        // speed events and the spare code never touch the map
        if (w_func == FUNC_READ || w_func == FUNC_WRITE) begin
            o_op.target = w_target;
            o_op.loc    = w_loc;
        end else begin
            o_op.target = TGT_LOCAL;
            o_op.loc    = LOC_NONE;
        end
    end

endmodule

// File: sv/bmd_queue.sv
// short fifo of classified words between the front and back ends
`include "assert_macros.svh"
module bmd_queue #(
    parameter int DEPTH = bmd_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  bmd_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output bmd_pkg::t_op o_op
);
    import bmd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_op           r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    `BMD_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, !o_full, "queue overflow")
    `BMD_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "queue underflow")

endmodule

// File: sv/bmd_back.sv
// back end: serves local stores, updates registers and holds the result word
`include "assert_macros.svh"
module bmd_back #(
    parameter int WORK_RAM_BYTES = bmd_pkg::WRAM_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  bmd_pkg::t_op                   i_op,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bmd_pkg::OUT_DATA_W-1:0] o_data,
    output logic [bmd_pkg::OUT_USER_W-1:0] o_user
);
    import bmd_pkg::*;

    localparam int          WA     = $clog2(WORK_RAM_BYTES);
    localparam int          OW     = 17;
    localparam logic [OW-1:0] WRAM_1X = OW'(WORK_RAM_BYTES);
    localparam logic [OW-1:0] WRAM_2X = OW'(2 * WORK_RAM_BYTES);

    // architectural registers
    logic [2:0] r_ram_bank,     n_ram_bank;
    logic [7:0] r_irq_enable,   n_irq_enable;
    logic [7:0] r_irq_pending,  n_irq_pending;
    logic       r_speed_double, n_speed_double;
    logic       r_switch_armed, n_switch_armed;

    // result register
    logic       r_out_valid, n_out_valid;
    t_target    r_target,    n_target;
    t_rsel      r_rsel,      n_rsel;
    logic [7:0] r_rdata,     n_rdata;
    logic       r_dma_start, n_dma_start;
    logic [7:0] r_dma_page,  n_dma_page;
    logic       r_out_speed, n_out_speed;

    logic          w_issue;
    logic          w_is_read;
    logic          w_is_write;
    logic [OW-1:0] w_off_raw;
    logic [OW-1:0] w_off_a;
    logic [OW-1:0] w_off_b;
    logic [WA-1:0] w_wram_addr;
    logic          w_wram_en;
    logic          w_hram_en;
    logic [7:0]    w_wram_q;
    logic [7:0]    w_hram_q;
    logic [7:0]    w_rdata;

    assign w_issue    = i_q_valid && (!r_out_valid || i_ready);
    assign o_pop      = w_issue;
    assign w_is_read  = (i_op.func == FUNC_READ);
    assign w_is_write = (i_op.func == FUNC_WRITE);

    // banked offset, wrapped into a work ram that may be smaller than eight banks
    assign w_off_raw = {2'b00, (i_op.bank_sel ? r_ram_bank : 3'd0), i_op.wram_low};
    assign w_off_a   = (w_off_raw >= WRAM_2X) ? w_off_raw - WRAM_2X : w_off_raw;
    assign w_off_b   = (w_off_a >= WRAM_1X) ? w_off_a - WRAM_1X : w_off_a;
    assign w_wram_addr = w_off_b[WA-1:0];

    assign w_wram_en = w_issue && (i_op.loc == LOC_WRAM) && (w_is_read || w_is_write);
    assign w_hram_en = w_issue && (i_op.loc == LOC_HRAM) && (w_is_read || w_is_write);

    bmd_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_wram (
        .i_clk   (i_clk),
        .i_en    (w_wram_en),
        .i_we    (w_is_write),
        .i_addr  (w_wram_addr),
        .i_wdata (i_op.wdata),
        .o_rdata (w_wram_q)
    );

    bmd_ram #(.WIDTH(8), .DEPTH(HRAM_BYTES)) u_hram (
        .i_clk   (i_clk),
        .i_en    (w_hram_en),
        .i_we    (w_is_write),
        .i_addr  (i_op.hram_idx),
        .i_wdata (i_op.wdata),
        .o_rdata (w_hram_q)
    );

    always_comb begin
        n_ram_bank     = r_ram_bank;
        n_irq_enable   = r_irq_enable;
        n_irq_pending  = r_irq_pending;
        n_speed_double = r_speed_double;
        n_switch_armed = r_switch_armed;
        n_out_valid    = r_out_valid;
        n_target       = r_target;
        n_rsel         = r_rsel;
        n_rdata        = r_rdata;
        n_dma_start    = r_dma_start;
        n_dma_page     = r_dma_page;
        n_out_speed    = r_out_speed;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_issue) begin
            n_out_valid = 1'b1;
            n_target    = i_op.target;
            n_rsel      = RSEL_REG;
            n_rdata     = 8'd0;
            n_dma_start = 1'b0;
            n_dma_page  = 8'd0;

            case (i_op.func)
                FUNC_READ: begin
                    case (i_op.loc)
                        LOC_WRAM: n_rsel  = RSEL_WRAM;
                        LOC_HRAM: n_rsel  = RSEL_HRAM;
                        LOC_IF:   n_rdata = r_irq_pending;
                        LOC_KEY1: n_rdata = {r_speed_double, 6'd0, r_switch_armed};
                        LOC_SVBK: n_rdata = {5'd0, r_ram_bank};
                        LOC_IE:   n_rdata = r_irq_enable;
                        default:  n_rdata = 8'd0;
                    endcase
                end
                FUNC_WRITE: begin
                    case (i_op.loc)
                        LOC_DMA: begin
                            n_dma_start = 1'b1;
                            n_dma_page  = i_op.wdata;
                        end
                        LOC_IF:   n_irq_pending  = i_op.wdata;
                        LOC_KEY1: n_switch_armed = i_op.wdata[0];
                        LOC_SVBK: begin
                            n_ram_bank = (i_op.wdata[2:0] == 3'd0) ? BANK_RESET
                                                                   : i_op.wdata[2:0];
                        end
                        LOC_IE:   n_irq_enable   = i_op.wdata;
                        default:  n_irq_enable   = r_irq_enable;
                    endcase
                end
                FUNC_SPEED: begin
                    n_speed_double = r_speed_double ^ r_switch_armed;
                    n_switch_armed = 1'b0;
                end
                default: n_rdata = 8'd0;
            endcase

            n_out_speed = n_speed_double;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_bank     <= BANK_RESET;
            r_irq_enable   <= 8'd0;
            r_irq_pending  <= 8'd0;
            r_speed_double <= 1'b0;
            r_switch_armed <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_ram_bank     <= n_ram_bank;
            r_irq_enable   <= n_irq_enable;
            r_irq_pending  <= n_irq_pending;
            r_speed_double <= n_speed_double;
            r_switch_armed <= n_switch_armed;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target    <= n_target;
        r_rsel      <= n_rsel;
        r_rdata     <= n_rdata;
        r_dma_start <= n_dma_start;
        r_dma_page  <= n_dma_page;
        r_out_speed <= n_out_speed;
    end

    // ram data arrives in the cycle after issue and holds while the word waits
    always_comb begin
        case (r_rsel)
            RSEL_WRAM: w_rdata = w_wram_q;
            RSEL_HRAM: w_rdata = w_hram_q;
            default:   w_rdata = r_rdata;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_data  = {6'd0, r_out_speed, r_dma_page, r_dma_start, w_rdata};
    assign o_user  = r_target;

    `BMD_ASSERT_IMPL(a_bank_nonzero, i_clk, i_rst_n, 1'b1, r_ram_bank != 3'd0,
        "work ram bank select is zero")
    `BMD_ASSERT_IMPL(a_dma_local, i_clk, i_rst_n, r_out_valid && r_dma_start,
        r_target == TGT_LOCAL, "dma start on a non-local word")
    `BMD_ASSERT_NEXT(a_speed_only_on_event, i_clk, i_rst_n,
        !(w_issue && i_op.func == FUNC_SPEED), $stable(r_speed_double),
        "speed mode changed without a switch event")
    `BMD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_out_valid && !i_ready,
        r_out_valid && $stable(r_target) && $stable(r_rsel),
        "result word lost while stalled")

endmodule

// File: sv/banked_memory_bus_decoder.sv
// top level of the banked memory bus decoder
//
// usage: each slave-side word is one cpu bus access. s_axis_tuser carries the
// function (read, write or speed switch event), s_axis_tdata the address and
// the write byte. for every accepted word exactly one master-side word comes
// back, in order: m_axis_tuser names the owner of the address, m_axis_tdata
// carries read data, the oam dma start flag and page, and the speed mode.
// a word accepted on the slave side is classified into a four-deep queue,
// issued to the local stores when the result register can take it, and shown
// on the master side from that register. throughput: one word per clock while
// m_axis_tready is high, set by the single port of each ram, which serves one
// access per cycle; the result is held in an output register.
// reset: bank select goes to one, interrupt enable and flag bytes, speed mode
// and armed bit clear, queue and output register empty. work ram and high ram
// are not cleared and hold nothing defined until written, so no clearing pass
// is needed and words are accepted straight after reset.
// stall: while m_axis_tready is low the result word holds, the back end stops
// issuing and the queue fills; s_axis_tready drops only when it is full.
module banked_memory_bus_decoder #(
    parameter int WORK_RAM_BYTES = bmd_pkg::WRAM_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // bits from 0: addr[15:0], wdata[23:16]
    input  logic [bmd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // bits from 0: func[1:0]
    input  logic [bmd_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // bits from 0: rdata[7:0], oam_dma_start[8], oam_dma_page[16:9],
    // double_speed[17], zero fill[23:18]
    output logic [bmd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // bits from 0: target[2:0]
    output logic [bmd_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import bmd_pkg::*;

    t_op  w_front_op;
    t_op  w_queue_op;
    logic w_queue_full;
    logic w_queue_valid;
    logic w_push;
    logic w_pop;

    // accept whenever the queue has room
    assign s_axis_tready = !w_queue_full;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    // classify the access by function and address
    bmd_front u_front (
        .i_func  (s_axis_tuser),
        .i_addr  (s_axis_tdata[15:0]),
        .i_wdata (s_axis_tdata[23:16]),
        .o_op    (w_front_op)
    );

    // decouples acceptance from issue
    bmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_op    (w_queue_op)
    );

    // local stores, registers and the result register
    bmd_back #(.WORK_RAM_BYTES(WORK_RAM_BYTES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_queue_valid),
        .i_op      (w_queue_op),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser)
    );

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the banked memory bus decoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bmd_pkg::*;

    // work ram size handed to the block, the predictor wraps offsets by it
    localparam int WRAM_BYTES   = 32768;
    // receiver hold-off under pressure, well past the queue depth
    localparam int HOLD_CYCLES  = 64;
    // cycles without any handshake before the run is abandoned
    localparam int STALL_LIMIT  = 600;
    // cycles left after the last result to catch stray words
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 600;

    // one expected result word
    typedef struct packed {
        t_target    target;
        logic [7:0] rdata;
        logic       dma_start;
        logic [7:0] dma_page;
        logic       dspeed;
    } t_bus_outcome;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // bits from 0: addr[15:0], wdata[23:16]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // bits from 0: func[1:0]
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // bits from 0: rdata[7:0], oam_dma_start[8], oam_dma_page[16:9],
    // double_speed[17], zero fill[23:18]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // bits from 0: target[2:0]
    logic [OUT_USER_W-1:0] m_axis_tuser;

    // predicted state of the local stores
    logic [7:0]  wram_img [WRAM_BYTES];
    bit          wram_set [WRAM_BYTES];
    logic [7:0]  hram_img [HRAM_BYTES];
    bit          hram_set [HRAM_BYTES];
    int unsigned wram_written [$];
    int unsigned hram_written [$];
    logic [2:0]  bank_now    = BANK_RESET;
    logic [7:0]  irq_en_now  = 8'h00;
    logic [7:0]  irq_flg_now = 8'h00;
    logic        dspeed_now  = 1'b0;
    logic        armed_now   = 1'b0;

    t_bus_outcome expected_results [$];

    int unsigned src_gap_max   = 19;
    int unsigned sink_gap_max  = 19;
    bit          hold_request  = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen  = 0;
    int unsigned quiet_cycles  = 0;

    banked_memory_bus_decoder #(
        .WORK_RAM_BYTES(WRAM_BYTES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // address decoding and local store behaviour
    // ---------------------------------------------------------------

    function automatic t_target owner_of(input logic [15:0] a);
        if (a <= ADDR_CART_LO_END) return TGT_CART;
        if (a <= ADDR_VRAM_END) return TGT_VIDEO;
        if (a <= ADDR_CART_HI_END) return TGT_CART;
        if (a <= ADDR_WRAM_END) return TGT_LOCAL;
        if (a <= ADDR_OAM_END) return TGT_VIDEO;
        if (a <= ADDR_HOLE_END) return TGT_UNMAPPED;
        if (a == ADDR_JOYPAD) return TGT_JOYPAD;
        if (a == ADDR_SB || a == ADDR_SC) return TGT_SERIAL;
        if (a >= ADDR_TIMER_LO && a <= ADDR_TIMER_HI) return TGT_TIMER;
        if (a inside {ADDR_IF, ADDR_OAM_DMA, ADDR_KEY1, ADDR_SVBK}) return TGT_LOCAL;
        // lcd, palette and vram bank registers belong to video
        if ((a >= 16'hFF40 && a <= 16'hFF45) || (a >= 16'hFF47 && a <= 16'hFF4B) ||
            a == 16'hFF4F || (a >= 16'hFF68 && a <= 16'hFF6B)) return TGT_VIDEO;
        if (a >= ADDR_HDMA_LO && a <= ADDR_HDMA_HI) return TGT_HDMA;
        if (a >= ADDR_HRAM_LO) return TGT_LOCAL;
        // audio and the rest of the io page
        return TGT_UNMAPPED;
    endfunction

    function automatic bit in_wram(input logic [15:0] a);
        return a >= 16'hC000 && a <= ADDR_WRAM_END;
    endfunction

    function automatic bit in_hram(input logic [15:0] a);
        return a >= ADDR_HRAM_LO && a < ADDR_IE;
    endfunction

    // upper 4k of each 8k half follows the bank select, echo included
    function automatic int unsigned wram_index(input logic [15:0] a);
        int unsigned bank;
        bank = a[12] ? int'(bank_now) : 0;
        return (int'(a[11:0]) + 4096 * bank) % WRAM_BYTES;
    endfunction

    function automatic bit read_defined(input logic [15:0] a);
        if (in_wram(a)) return wram_set[wram_index(a)];
        if (in_hram(a)) return hram_set[a - ADDR_HRAM_LO];
        return 1'b1;
    endfunction

    function automatic logic [7:0] local_byte(input logic [15:0] a);
        if (in_wram(a)) return wram_img[wram_index(a)];
        if (a == ADDR_IF) return irq_flg_now;
        if (a == ADDR_KEY1) return {dspeed_now, 6'b000000, armed_now};
        if (a == ADDR_SVBK) return {5'b00000, bank_now};
        if (in_hram(a)) return hram_img[a - ADDR_HRAM_LO];
        if (a == ADDR_IE) return irq_en_now;
        return 8'h00;
    endfunction

    function automatic void store_local(input logic [15:0] a, input logic [7:0] d);
        int unsigned idx;
        if (in_wram(a)) begin
            idx = wram_index(a);
            if (!wram_set[idx]) wram_written.push_back(idx);
            wram_set[idx] = 1'b1;
            wram_img[idx] = d;
        end else if (in_hram(a)) begin
            idx = a - ADDR_HRAM_LO;
            if (!hram_set[idx]) hram_written.push_back(idx);
            hram_set[idx] = 1'b1;
            hram_img[idx] = d;
        end else if (a == ADDR_IF) begin
            irq_flg_now = d;
        end else if (a == ADDR_KEY1) begin
            armed_now = d[0];
        end else if (a == ADDR_SVBK) begin
            // bank 0 cannot be selected in the switchable window
            bank_now = (d[2:0] == 3'd0) ? 3'd1 : d[2:0];
        end else if (a == ADDR_IE) begin
            irq_en_now = d;
        end
    endfunction

    // works out the result word of one accepted access and updates the state
    function automatic void predict_access(input t_func f, input logic [15:0] a,
                                           input logic [7:0] d);
        t_bus_outcome r;
        r.target    = TGT_LOCAL;
        r.rdata     = 8'h00;
        r.dma_start = 1'b0;
        r.dma_page  = 8'h00;
        case (f)
            FUNC_READ: begin
                r.target = owner_of(a);
                if (r.target == TGT_LOCAL) r.rdata = local_byte(a);
            end
            FUNC_WRITE: begin
                r.target = owner_of(a);
                if (r.target == TGT_LOCAL) begin
                    if (a == ADDR_OAM_DMA) begin
                        r.dma_start = 1'b1;
                        r.dma_page  = d;
                    end else begin
                        store_local(a, d);
                    end
                end
            end
            FUNC_SPEED: begin
                // an armed switch toggles the speed, the event always disarms
                if (armed_now) dspeed_now = ~dspeed_now;
                armed_now = 1'b0;
            end
            default: begin
                // unused function code does nothing
            end
        endcase
        r.dspeed = dspeed_now;
        expected_results.push_back(r);
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // finds an address that reads back a byte already written, if any
    function automatic bit pick_stored_read(output logic [15:0] a);
        int unsigned off;
        int unsigned bk;
        logic [11:0] low;
        a = 16'h0000;
        if (hram_written.size() != 0 && $urandom_range(0, 2) == 0) begin
            a = ADDR_HRAM_LO + 16'(hram_written[$urandom_range(0, hram_written.size() - 1)]);
            return 1'b1;
        end
        for (int tries = 0; tries < 6; tries++) begin
            if (wram_written.size() == 0) return 1'b0;
            off = wram_written[$urandom_range(0, wram_written.size() - 1)];
            low = 12'(off);
            bk  = off / 4096;
            if (bk == 0) begin
                a = {($urandom_range(0, 1) != 0) ? 4'hE : 4'hC, low};
                return 1'b1;
            end
            if (bk == int'(bank_now)) begin
                // the echo of the banked half stops at FDFF
                a = {(low <= 12'hDFF && $urandom_range(0, 1) != 0) ? 4'hF : 4'hD, low};
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // one random access, weighted towards the local stores and io page
    function automatic void draw_access(output t_func f, output logic [15:0] a,
                                        output logic [7:0] d);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        d = 8'($urandom);
        a = 16'($urandom);
        f = ($urandom_range(0, 1) != 0) ? FUNC_WRITE : FUNC_READ;
        if (pick < 8) begin
            f = t_func'($urandom_range(0, 3));
        end else if (pick < 26) begin
            // anywhere in the map
        end else if (pick < 44) begin
            a = (pick < 41) ? {8'hFF, 1'b0, 7'($urandom)} : ADDR_IE;
        end else if (pick < 62) begin
            f = FUNC_WRITE;
            if ($urandom_range(0, 3) == 0) a = ADDR_HRAM_LO + 16'($urandom_range(0, 126));
            else a = 16'($urandom_range(16'hC000, 16'hFDFF));
        end else if (pick < 86) begin
            if (pick_stored_read(a)) begin
                f = FUNC_READ;
            end else begin
                f = FUNC_WRITE;
                a = 16'($urandom_range(16'hC000, 16'hFDFF));
            end
        end else if (pick < 92) begin
            f = FUNC_WRITE;
            a = ADDR_SVBK;
        end else if (pick < 96) begin
            f = FUNC_WRITE;
            a = ADDR_KEY1;
        end else begin
            f = FUNC_SPEED;
        end
        // never read a ram byte that holds nothing yet
        if (f == FUNC_READ && !read_defined(a)) f = FUNC_WRITE;
    endfunction

    // offers one word after a random gap, starts and ends at a falling edge
    task automatic send_access(input t_func f, input logic [15:0] a, input logic [7:0] d);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {d, a};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_access(f, a, d);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
            $display("%0t ns: result word %0d: %s", $time, results_seen, what);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // external owners, the unmapped hole and audio all return zero data
    task automatic test_address_map();
        send_access(FUNC_READ, 16'h0000, 8'h00);
        send_access(FUNC_READ, ADDR_VRAM_END, 8'hFF);
        send_access(FUNC_WRITE, 16'hFEA0, 8'hFF);
        send_access(FUNC_READ, ADDR_JOYPAD, 8'h00);
        send_access(FUNC_READ, ADDR_SC, 8'h00);
        send_access(FUNC_WRITE, ADDR_TIMER_HI, 8'h55);
        send_access(FUNC_READ, 16'hFF3F, 8'h00);
        send_access(FUNC_READ, ADDR_HDMA_HI, 8'h00);
    endtask

    // interrupt bytes and the dma trigger, which reads back as zero
    task automatic test_local_registers();
        send_access(FUNC_WRITE, ADDR_IE, 8'hFF);
        send_access(FUNC_READ, ADDR_IE, 8'h00);
        send_access(FUNC_WRITE, ADDR_IF, 8'hA5);
        send_access(FUNC_WRITE, ADDR_OAM_DMA, 8'hC3);
        send_access(FUNC_READ, ADDR_OAM_DMA, 8'h00);
    endtask

    // bank select of zero, the echo windows and high ram at its top end
    task automatic test_ram_banking();
        send_access(FUNC_WRITE, ADDR_SVBK, 8'hF8);
        send_access(FUNC_READ, ADDR_SVBK, 8'h00);
        send_access(FUNC_WRITE, 16'hD000, 8'h5A);
        send_access(FUNC_READ, 16'hF000, 8'h00);
        send_access(FUNC_WRITE, ADDR_SVBK, 8'h07);
        send_access(FUNC_WRITE, ADDR_WRAM_END, 8'h00);
        send_access(FUNC_READ, 16'hDDFF, 8'h00);
        send_access(FUNC_WRITE, 16'hFFFE, 8'h81);
        send_access(FUNC_READ, 16'hFFFE, 8'h00);
    endtask

    // armed switch toggles, a second one without arming does not
    task automatic test_speed_switch();
        send_access(FUNC_WRITE, ADDR_KEY1, 8'hFF);
        send_access(FUNC_READ, ADDR_KEY1, 8'h00);
        send_access(FUNC_SPEED, 16'hFFFF, 8'hFF);
        send_access(FUNC_SPEED, 16'h0000, 8'h00);
        send_access(FUNC_NONE, ADDR_IE, 8'h3C);
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        t_func       f;
        logic [15:0] a;
        logic [7:0]  d;
        src_gap_max  = 0;
        sink_gap_max = 0;
        hold_request = 1'b1;
        for (int n = 0; n < 24; n++) begin
            draw_access(f, a, d);
            send_access(f, a, d);
        end
    endtask

    task automatic test_random_traffic();
        t_func       f;
        logic [15:0] a;
        logic [7:0]  d;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // new idling mix every 50 words, including runs with no gaps
            if (n % 50 == 0) begin
                src_gap_max  = ($urandom_range(0, 1) != 0) ? 19 : 0;
                sink_gap_max = ($urandom_range(0, 1) != 0) ? 19 : 0;
            end
            draw_access(f, a, d);
            send_access(f, a, d);
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_address_map();
        test_local_registers();
        test_ram_banking();
        test_speed_switch();
        test_backpressure();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        // wait for every outstanding result, the watchdog bounds this
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // receiver: random gap before taking each word, long hold when asked
    initial begin : result_sink
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            gap = $urandom_range(0, sink_gap_max);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // compares each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_bus_outcome want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.target)
                    report_mismatch($sformatf("target %0d, expected %s",
                                              m_axis_tuser, want.target.name()));
                if (m_axis_tdata[7:0] !== want.rdata)
                    report_mismatch($sformatf("rdata %02h, expected %02h",
                                              m_axis_tdata[7:0], want.rdata));
                if (m_axis_tdata[8] !== want.dma_start)
                    report_mismatch($sformatf("oam dma start %b, expected %b",
                                              m_axis_tdata[8], want.dma_start));
                if (m_axis_tdata[16:9] !== want.dma_page)
                    report_mismatch($sformatf("oam dma page %02h, expected %02h",
                                              m_axis_tdata[16:9], want.dma_page));
                if (m_axis_tdata[17] !== want.dspeed)
                    report_mismatch($sformatf("double speed %b, expected %b",
                                              m_axis_tdata[17], want.dspeed));
                if (m_axis_tdata[23:18] !== 6'b000000)
                    report_mismatch($sformatf("fill bits %b not zero", m_axis_tdata[23:18]));
            end
            results_seen++;
        end
    end

    // watchdog on cycles in which neither side moves a word
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

// File: files.f
+incdir+sv
sv/bmd_pkg.sv
sv/bmd_ram.sv
sv/bmd_front.sv
sv/bmd_queue.sv
sv/bmd_back.sv
sv/banked_memory_bus_decoder.sv
tb/sv/testbench.sv
